/* rtl/core/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// shared sizes, types and state codes of the lru page replacement unit
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int RANK_W    = SLOT_W;
  localparam int CFG_W     = 4;
  localparam int TOTAL_W   = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lpr_state_t;

  // recency update command from the controller to the rank cells
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              age_all;
    logic [CNT_W-1:0]  filled;
  } lpr_touch_t;

endpackage

`default_nettype wire

/* rtl/core/lru_page_replacement_unit.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// lru page replacement over a bank of page frames with running hit counts
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries one page reference per item; the
// result channel out_valid/out_ready returns one item per reference with
// hit flag, slot, evicted page and saturating hit and fault totals.
// cfg_valid/cfg_ready writes frames_in_use (0 acts as 1, above 8 as 8);
// cfg_ready is always high, write only while the unit is idle.
// the frame pages sit in a small ram that is scanned one entry a cycle with
// a registered read; ranks live in per-frame cells that age in parallel.
// a reference is scanned in slot order over the filled frames, a hit ends
// the scan early, and an update step then writes the result; the next
// reference is taken only once the unit is back in idle.
// the result register decouples the sides: a new item is accepted while a
// result still waits, and the unit holds in its update step until that
// result is taken. reset (rst_n low, synchronous) empties all frames, clears
// the ranks and totals and sets frames_in_use to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lpr_pkg::CFG_W-1:0]      cfg_frames_in_use,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lpr_pkg::PAGE_BITS-1:0]  in_page_number,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_was_hit,
  output logic      [lpr_pkg::SLOT_W-1:0]     out_slot_used,
  output logic                                out_evicted_valid,
  output logic      [lpr_pkg::PAGE_BITS-1:0]  out_evicted_page,
  output logic      [lpr_pkg::TOTAL_W-1:0]    out_hits_so_far,
  output logic      [lpr_pkg::TOTAL_W-1:0]    out_faults_so_far
);

  lpr_pkg::lpr_state_t state_r, state_nxt;

  logic [lpr_pkg::CFG_W-1:0]     cfg_r;
  logic [lpr_pkg::CNT_W-1:0]     filled_r;
  logic [lpr_pkg::TOTAL_W-1:0]   hit_total_r;
  logic [lpr_pkg::TOTAL_W-1:0]   fault_total_r;
  logic [lpr_pkg::CNT_W-1:0]     rd_idx_r;
  logic                          chk_vld_r;
  logic                          hit_found_r;
  logic                          out_valid_r;

  logic [lpr_pkg::PAGE_BITS-1:0] page_r;
  logic [lpr_pkg::CNT_W-1:0]     limit_r;
  logic [lpr_pkg::SLOT_W-1:0]    victim_r;
  logic [lpr_pkg::SLOT_W-1:0]    chk_idx_r;
  logic [lpr_pkg::SLOT_W-1:0]    hit_slot_r;
  logic [lpr_pkg::PAGE_BITS-1:0] victim_page_r;
  logic                          out_was_hit_r;
  logic [lpr_pkg::SLOT_W-1:0]    out_slot_r;
  logic                          out_ev_valid_r;
  logic [lpr_pkg::PAGE_BITS-1:0] out_ev_page_r;

  logic [lpr_pkg::CNT_W-1:0]     limit_cur;
  logic [lpr_pkg::SLOT_W-1:0]    victim_cur;
  logic [lpr_pkg::PAGE_BITS-1:0] ram_rdata;
  logic                          in_fire;
  logic                          out_free;
  logic                          hit_now;
  logic                          issue;
  logic                          upd_fire;
  logic                          is_fill;
  logic                          is_evict;
  logic [lpr_pkg::SLOT_W-1:0]    upd_slot;
  logic                          ram_we;
  lpr_pkg::lpr_touch_t           touch;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // clamp of the configured frame count into 1..FRAMES
  always_comb begin
    if (cfg_r == '0) begin
      limit_cur = lpr_pkg::CNT_W'(1);
    end else if (int'(cfg_r) > lpr_pkg::FRAMES) begin
      limit_cur = lpr_pkg::CNT_W'(lpr_pkg::FRAMES);
    end else begin
      limit_cur = lpr_pkg::CNT_W'(cfg_r);
    end
  end

  assign hit_now = chk_vld_r && (ram_rdata == page_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (!issue) begin
          state_nxt = lpr_pkg::ST_UPDATE;
        end
      end
      lpr_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = lpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    upd_fire = 1'b0;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lpr_pkg::ST_SCAN: begin
        // stop reading once the page is found
        issue = (rd_idx_r < filled_r) && !hit_found_r && !hit_now;
      end
      lpr_pkg::ST_UPDATE: begin
        upd_fire = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign is_fill  = !hit_found_r && (filled_r < limit_r);
  assign is_evict = !hit_found_r && !is_fill;

  always_comb begin
    if (hit_found_r) begin
      upd_slot = hit_slot_r;
    end else if (is_fill) begin
      upd_slot = lpr_pkg::SLOT_W'(filled_r);
    end else begin
      upd_slot = victim_r;
    end
  end

  assign ram_we        = upd_fire && !hit_found_r;
  assign touch.en      = upd_fire;
  assign touch.slot    = upd_slot;
  assign touch.age_all = is_fill;
  assign touch.filled  = filled_r;

  lpr_ram #(
    .WIDTH (lpr_pkg::PAGE_BITS),
    .DEPTH (lpr_pkg::FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_slot),
    .wdata (page_r),
    .re    (issue),
    .raddr (rd_idx_r[lpr_pkg::SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  lpr_rank_bank u_rank_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .touch  (touch),
    .limit  (limit_cur),
    .victim (victim_cur)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lpr_pkg::ST_IDLE;
      cfg_r         <= lpr_pkg::CFG_RESET;
      filled_r      <= '0;
      hit_total_r   <= '0;
      fault_total_r <= '0;
      rd_idx_r      <= '0;
      chk_vld_r     <= 1'b0;
      hit_found_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_frames_in_use;
      end
      if (in_fire) begin
        rd_idx_r    <= '0;
        chk_vld_r   <= 1'b0;
        hit_found_r <= 1'b0;
      end else if (state_r == lpr_pkg::ST_SCAN) begin
        chk_vld_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        if (hit_now) begin
          hit_found_r <= 1'b1;
        end
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
        if (is_fill) begin
          filled_r <= filled_r + 1'b1;
        end
        if (hit_found_r) begin
          if (hit_total_r != '1) begin
            hit_total_r <= hit_total_r + 1'b1;
          end
        end else if (fault_total_r != '1) begin
          fault_total_r <= fault_total_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r   <= in_page_number;
      limit_r  <= limit_cur;
      victim_r <= victim_cur;
    end
    chk_idx_r <= rd_idx_r[lpr_pkg::SLOT_W-1:0];
    if (hit_now && !hit_found_r) begin
      hit_slot_r <= chk_idx_r;
    end
    if (chk_vld_r && chk_idx_r == victim_r) begin
      victim_page_r <= ram_rdata;
    end
    if (upd_fire) begin
      out_was_hit_r  <= hit_found_r;
      out_slot_r     <= upd_slot;
      out_ev_valid_r <= is_evict;
      out_ev_page_r  <= is_evict ? victim_page_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_was_hit       = out_was_hit_r;
  assign out_slot_used     = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  // totals only move on an update, which waits for this result to leave
  assign out_hits_so_far   = hit_total_r;
  assign out_faults_so_far = fault_total_r;

endmodule

`default_nettype wire

/* rtl/core/lpr_ram.sv */
// ----------------------------------------------------------------------------
// lpr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lpr_rank_bank.sv */
// ----------------------------------------------------------------------------
// lpr_rank_bank
// recency rank cells, one per frame: parallel aging and victim selection
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_rank_bank (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lpr_pkg::lpr_touch_t         touch,
  input  wire logic [lpr_pkg::CNT_W-1:0]   limit,
  output logic      [lpr_pkg::SLOT_W-1:0]  victim
);

  logic [lpr_pkg::RANK_W-1:0] rank_r   [lpr_pkg::FRAMES];
  logic [lpr_pkg::RANK_W-1:0] rank_nxt [lpr_pkg::FRAMES];
  logic [lpr_pkg::RANK_W-1:0] old_rank;

  assign old_rank = rank_r[touch.slot];

  // touched frame becomes most recent, valid frames more recent than it age; on a fill all valid frames age
  always_comb begin
    for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
      rank_nxt[j] = rank_r[j];
      if (touch.en) begin
        if (touch.slot == lpr_pkg::SLOT_W'(j)) begin
          rank_nxt[j] = '0;
        end else if (j < int'(touch.filled) &&
                     (touch.age_all || rank_r[j] < old_rank)) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  // oldest frame among slots below the limit, first one wins a tie
  always_comb begin
    logic                       found;
    logic [lpr_pkg::RANK_W-1:0] best;
    found  = 1'b0;
    best   = '0;
    victim = '0;
    for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
      if (j < int'(limit) && (!found || rank_r[j] > best)) begin
        found  = 1'b1;
        best   = rank_r[j];
        victim = lpr_pkg::SLOT_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

/* test/lru_page_replacement_unit_test.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_test
// self-checking bench for the lru page replacement unit: directed references
// cover the frame limit clamps, slot-order filling, hits above a lowered
// limit and eviction order; random references from a small page pool run
// under three idle mixes, a long output stall and a drain pause, and every
// result item is checked against a cycle-free lru model of the frame bank
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_test;

  localparam int DRAIN_CYCLES = 24;
  localparam int POOL_SIZE    = 12;

  typedef struct packed {
    logic                          was_hit;
    logic [lpr_pkg::SLOT_W-1:0]    slot;
    logic                          evicted;
    logic [lpr_pkg::PAGE_BITS-1:0] evicted_page;
    logic [lpr_pkg::TOTAL_W-1:0]   hits;
    logic [lpr_pkg::TOTAL_W-1:0]   faults;
  } page_outcome_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lpr_pkg::CFG_W-1:0]     cfg_frames_in_use = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [lpr_pkg::PAGE_BITS-1:0] in_page_number = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_was_hit;
  logic [lpr_pkg::SLOT_W-1:0]    out_slot_used;
  logic                          out_evicted_valid;
  logic [lpr_pkg::PAGE_BITS-1:0] out_evicted_page;
  logic [lpr_pkg::TOTAL_W-1:0]   out_hits_so_far;
  logic [lpr_pkg::TOTAL_W-1:0]   out_faults_so_far;

  // model of the frame bank
  logic [lpr_pkg::PAGE_BITS-1:0] resident_page [lpr_pkg::FRAMES];
  logic                          resident_valid [lpr_pkg::FRAMES];
  logic [lpr_pkg::RANK_W-1:0]    age_rank [lpr_pkg::FRAMES];
  logic [lpr_pkg::CNT_W-1:0]     frames_filled;
  logic [lpr_pkg::TOTAL_W-1:0]   hit_count;
  logic [lpr_pkg::TOTAL_W-1:0]   fault_count;
  logic [lpr_pkg::CFG_W-1:0]     frame_limit;

  page_outcome_t                 pending_outcomes [$];
  logic [lpr_pkg::PAGE_BITS-1:0] page_pool [POOL_SIZE];
  int                            error_count = 0;
  int                            send_idle_pct = 0;
  int                            recv_idle_pct = 0;
  int                            stall_cycles = 0;

  lru_page_replacement_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_was_hit       (out_was_hit),
    .out_slot_used     (out_slot_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hits_so_far   (out_hits_so_far),
    .out_faults_so_far (out_faults_so_far)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // make slot s the most recent, frames more recent than old_rank age by one
  function automatic void promote(input int s, input int old_rank);
    for (int j = 0; j < lpr_pkg::FRAMES; j++) begin
      if (j != s && resident_valid[j] && int'(age_rank[j]) < old_rank) begin
        age_rank[j] = age_rank[j] + 1'b1;
      end
    end
    age_rank[s] = '0;
  endfunction

  function automatic page_outcome_t lru_reference(
    input logic [lpr_pkg::PAGE_BITS-1:0] page
  );
    page_outcome_t r;
    int limit;
    int hit_slot;
    int victim;
    int oldest;
    r = '0;
    limit = int'(frame_limit);
    if (limit < 1) limit = 1;
    if (limit > lpr_pkg::FRAMES) limit = lpr_pkg::FRAMES;
    hit_slot = -1;
    for (int j = lpr_pkg::FRAMES - 1; j >= 0; j--) begin
      if (resident_valid[j] && resident_page[j] == page) hit_slot = j;
    end
    if (hit_slot >= 0) begin
      r.was_hit = 1'b1;
      r.slot = lpr_pkg::SLOT_W'(hit_slot);
      promote(hit_slot, int'(age_rank[hit_slot]));
      if (hit_count != '1) hit_count = hit_count + 1'b1;
    end else begin
      if (int'(frames_filled) < limit) begin
        victim = int'(frames_filled);
        resident_valid[victim] = 1'b1;
        resident_page[victim] = page;
        promote(victim, lpr_pkg::FRAMES);
        frames_filled = frames_filled + 1'b1;
      end else begin
        // only slots below the limit are candidates, even with more filled
        victim = 0;
        oldest = -1;
        for (int j = 0; j < limit; j++) begin
          if (resident_valid[j] && int'(age_rank[j]) > oldest) begin
            oldest = int'(age_rank[j]);
            victim = j;
          end
        end
        r.evicted = 1'b1;
        r.evicted_page = resident_page[victim];
        resident_page[victim] = page;
        promote(victim, int'(age_rank[victim]));
      end
      r.slot = lpr_pkg::SLOT_W'(victim);
      if (fault_count != '1) fault_count = fault_count + 1'b1;
    end
    r.hits = hit_count;
    r.faults = fault_count;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10) begin
        $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    page_outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result item: slot %0d hit %b", out_slot_used, out_was_hit);
        end
      end else begin
        want = pending_outcomes.pop_front();
        check_field("was_hit", 32'(want.was_hit), 32'(out_was_hit));
        check_field("slot_used", 32'(want.slot), 32'(out_slot_used));
        check_field("evicted_valid", 32'(want.evicted), 32'(out_evicted_valid));
        check_field("evicted_page", 32'(want.evicted_page), 32'(out_evicted_page));
        check_field("hits_so_far", want.hits, out_hits_so_far);
        check_field("faults_so_far", want.faults, out_faults_so_far);
      end
    end
  end

  // receiver: random idling, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at a falling edge with in_valid still high
  task automatic send_page(input logic [lpr_pkg::PAGE_BITS-1:0] page);
    page_outcome_t outcome;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (!in_ready);
    outcome = lru_reference(page);
    pending_outcomes.insert(pending_outcomes.size(), outcome);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    // the unit is already back in idle when a result leaves
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame_limit(input logic [lpr_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_frames_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    frame_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_zero_limit();
    write_frame_limit(4'd0);
    send_page(16'h0000);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hFFFF);
  endtask

  task automatic test_partial_fill();
    write_frame_limit(4'd3);
    send_page(16'h1234);
    send_page(16'h5555);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h5555);
  endtask

  task automatic test_oversize_limit();
    write_frame_limit(4'd15);
    for (int p = 1; p <= 5; p++) send_page(lpr_pkg::PAGE_BITS'(p));
    send_page(16'h8000);
    send_page(16'h5555);
    send_page(16'h7FFF);
  endtask

  task automatic test_lowered_limit();
    write_frame_limit(4'd2);
    // pages held above the limit still hit
    send_page(16'h0005);
    send_page(16'h0003);
    send_page(16'h0F0F);
    send_page(16'hF0F0);
    send_page(16'h0F0F);
    send_page(16'h0001);
  endtask

  task automatic test_random_traffic(input logic [lpr_pkg::CFG_W-1:0] limit,
                                     input int count,
                                     input int send_pct, input int recv_pct);
    int span;
    write_frame_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    // keep most of the pool so earlier residents still hit
    repeat (4) page_pool[$urandom_range(POOL_SIZE - 1)] = lpr_pkg::PAGE_BITS'($urandom);
    span = (limit == 0) ? 1 : (limit > lpr_pkg::FRAMES) ? lpr_pkg::FRAMES : int'(limit);
    span = (span + 3 > POOL_SIZE) ? POOL_SIZE - 1 : span + 2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) send_page(page_pool[$urandom_range(span)]);
      else send_page(lpr_pkg::PAGE_BITS'($urandom));
    end
  endtask

  task automatic test_backpressure();
    write_frame_limit(4'd7);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles = 200;
    for (int n = 0; n < 20; n++) send_page(page_pool[$urandom_range(POOL_SIZE - 1)]);
    // sender holds until every result is back
    wait_drained();
    for (int n = 0; n < 20; n++) send_page(page_pool[$urandom_range(POOL_SIZE - 1)]);
  endtask

  initial begin
    foreach (resident_valid[i]) begin
      resident_page[i] = '0;
      resident_valid[i] = 1'b0;
      age_rank[i] = '0;
    end
    frames_filled = '0;
    hit_count = '0;
    fault_count = '0;
    frame_limit = lpr_pkg::CFG_RESET;
    foreach (page_pool[i]) page_pool[i] = lpr_pkg::PAGE_BITS'($urandom);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_zero_limit();
    test_partial_fill();
    test_oversize_limit();
    test_lowered_limit();
    test_random_traffic(4'd8, 60, 29, 88);
    test_random_traffic(4'd6, 55, 29, 88);
    test_random_traffic(4'd1, 50, 88, 29);
    test_random_traffic(4'd3, 55, 88, 29);
    test_random_traffic(4'd8, 60, 0, 0);
    test_random_traffic(lpr_pkg::CFG_W'($urandom_range(15, 9)), 60, 0, 0);
    test_backpressure();
    wait_drained();

    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
